[rtl/core/cau_pkg.sv]
// Shared types, codes, tables and helper functions of the complex arithmetic unit.
package cau_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_STEPS = 31;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_DIVR  = 4'd5;
    localparam logic [3:0] OP_NEG   = 4'd6;
    localparam logic [3:0] OP_MOD   = 4'd7;
    localparam logic [3:0] OP_ARG   = 4'd8;
    localparam logic [3:0] OP_EQ    = 4'd9;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ARG0 = 2'd2;

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1
    };

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] rr;
        logic [31:0] ri;
        logic        eq;
        logic        ovf;
        logic [1:0]  err;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] den;
        logic [63:0] dvd_re;
        logic [63:0] dvd_im;
        logic [63:0] rem_re;
        logic [63:0] rem_im;
        logic [32:0] quo_re;
        logic [32:0] quo_im;
        logic        big_re;
        logic        big_im;
        logic [63:0] sq_n;
        logic [63:0] sq_res;
        logic [33:0] cx;
        logic [33:0] cy;
        logic [32:0] cz;
    } cau_lane_t;

    // Saturates a wide signed value to 32 bits; the top bit of the result is the overflow flag.
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end
        else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Applies the sign to a quotient magnitude and saturates; the top bit is the overflow flag.
    function automatic logic [32:0] div_out(input logic [32:0] quo, input logic big,
                                            input logic neg);
        logic [32:0] r;
        if (neg) begin
            if (big || quo > 33'h0_8000_0000) begin
                r = {1'b1, 32'h8000_0000};
            end
            else begin
                r = {1'b0, 32'(33'd0 - quo)};
            end
        end
        else begin
            if (big || quo > 33'h0_7FFF_FFFF) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end
            else begin
                r = {1'b0, quo[31:0]};
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: setup stages, cell chain and result stage.
//
// Each request produces exactly one result word, marked by done (default format Q16.16),
// after it has passed through two setup stages, a chain of
// 64 + FRAC_BITS cells that each deliver one quotient bit per part, and one result stage.
// The chain is fully pipelined, so busy stays low and a new word may start every cycle;
// the receiver has to take every result in the cycle it appears.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  req_type,
    input  logic [31:0] a_re,
    input  logic [31:0] a_im,
    input  logic [31:0] b_re,
    input  logic [31:0] b_im,
    output logic        done,
    output logic [31:0] res_re,
    output logic [31:0] res_im,
    output logic        equal_flag,
    output logic        overflow,
    output logic [1:0]  error_code
);
    import cau_pkg::*;

    localparam int NCELL = 64 + FRAC_BITS;
    localparam int DROP = 30 - FRAC_BITS;
    localparam int RND_SH = (FRAC_BITS < 30) ? 29 - FRAC_BITS : 0;
    localparam logic signed [33:0] RND = (FRAC_BITS < 30) ? 34'sd1 <<< RND_SH : 34'sd0;

    logic      vld [NCELL + 1];
    cau_lane_t lane [NCELL + 1];
    logic      done_reg;
    logic [31:0] rr_reg, ri_reg;
    logic      eq_reg, ovf_reg;
    logic [1:0] err_reg;
    logic [31:0] rr_next, ri_next;
    logic      ovf_next;

    assign busy = 1'b0;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start & ~busy),
        .op       (req_type),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .out_vld  (vld[0]),
        .out_lane (lane[0])
    );

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        cau_cell #(.IDX(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (vld[g]),
            .in_lane  (lane[g]),
            .out_vld  (vld[g + 1]),
            .out_lane (lane[g + 1])
        );
    end

    always_comb
    begin
        cau_lane_t          l;
        logic [32:0]        q_re, q_im, za;
        logic signed [33:0] zr;
        l = lane[NCELL];
        rr_next = l.rr;
        ri_next = l.ri;
        ovf_next = l.ovf;
        q_re = div_out(l.quo_re, l.big_re, l.neg_re);
        q_im = div_out(l.quo_im, l.big_im, l.neg_im);
        zr = (34'($signed(l.cz)) + RND) >>> DROP;
        za = sat32(66'(zr));
        if ((l.op == OP_DIV || l.op == OP_DIVR) && l.err == ERR_OK)
        begin
            rr_next = q_re[31:0];
            ri_next = q_im[31:0];
            ovf_next = q_re[32] | q_im[32];
        end
        else if (l.op == OP_MOD)
        begin
            ri_next = '0;
            if (l.sq_res > 64'h7FFF_FFFF)
            begin
                rr_next = 32'h7FFF_FFFF;
                ovf_next = 1'b1;
            end
            else
            begin
                rr_next = l.sq_res[31:0];
                ovf_next = 1'b0;
            end
        end
        else if (l.op == OP_ARG && l.err == ERR_OK)
        begin
            rr_next = za[31:0];
            ri_next = '0;
            ovf_next = za[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld[NCELL];
        end
    end

    always_ff @(posedge clk)
    begin
        rr_reg <= rr_next;
        ri_reg <= ri_next;
        eq_reg <= lane[NCELL].eq;
        ovf_reg <= ovf_next;
        err_reg <= lane[NCELL].err;
    end

    assign done = done_reg;
    assign res_re = rr_reg;
    assign res_im = ri_reg;
    assign equal_flag = eq_reg;
    assign overflow = ovf_reg;
    assign error_code = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && error_code != ERR_OK |-> res_re == '0 && res_im == '0 && !overflow)
        else $error("An error result carries a nonzero value.");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && equal_flag |-> error_code == ERR_OK && !overflow && res_re == '0)
        else $error("A compare result carries a value or a flag.");

endmodule

[rtl/core/cau_front.sv]
// Operand products and per-operation setup ahead of the cell chain.
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [3:0]         op,
    input  logic [31:0]        a_re,
    input  logic [31:0]        a_im,
    input  logic [31:0]        b_re,
    input  logic [31:0]        b_im,
    output logic               out_vld,
    output cau_pkg::cau_lane_t out_lane
);
    import cau_pkg::*;

    logic              vld0_reg;
    logic [3:0]        op_reg;
    logic [31:0]       ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic              vld1_reg;
    cau_lane_t         lane_reg;
    cau_lane_t         lane_next;
    logic [31:0]       sq0, sq1;

    assign sq0 = (op == OP_MOD) ? a_re : b_re;
    assign sq1 = (op == OP_MOD) ? a_im : b_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_vld;
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op;
        ar_reg <= a_re;
        ai_reg <= a_im;
        br_reg <= b_re;
        bi_reg <= b_im;
        p0_reg <= $signed(a_re) * $signed(b_re);
        p1_reg <= $signed(a_im) * $signed(b_im);
        p2_reg <= $signed(a_im) * $signed(b_re);
        p3_reg <= $signed(a_re) * $signed(b_im);
        p4_reg <= $signed(sq0) * $signed(sq0);
        p5_reg <= $signed(sq1) * $signed(sq1);
        lane_reg <= lane_next;
    end

    always_comb
    begin
        logic signed [65:0] s_re, s_im;
        logic [32:0]        q_re, q_im;
        logic [63:0]        den4;
        logic signed [32:0] mag_ar, mag_ai, mag_br;
        lane_next = '0;
        lane_next.op = op_reg;
        s_re = '0;
        s_im = '0;
        q_re = '0;
        q_im = '0;
        den4 = 64'(p4_reg) + 64'(p5_reg);
        mag_ar = ar_reg[31] ? -33'($signed(ar_reg)) : 33'($signed(ar_reg));
        mag_ai = ai_reg[31] ? -33'($signed(ai_reg)) : 33'($signed(ai_reg));
        mag_br = br_reg[31] ? -33'($signed(br_reg)) : 33'($signed(br_reg));
        unique case (op_reg)
            OP_ADD, OP_SUB, OP_NEG:
            begin
                if (op_reg == OP_ADD)
                begin
                    s_re = 66'($signed(ar_reg)) + 66'($signed(br_reg));
                    s_im = 66'($signed(ai_reg)) + 66'($signed(bi_reg));
                end
                else if (op_reg == OP_SUB)
                begin
                    s_re = 66'($signed(ar_reg)) - 66'($signed(br_reg));
                    s_im = 66'($signed(ai_reg)) - 66'($signed(bi_reg));
                end
                else
                begin
                    s_re = -66'($signed(ar_reg));
                    s_im = -66'($signed(ai_reg));
                end
                q_re = sat32(s_re);
                q_im = sat32(s_im);
                lane_next.rr = q_re[31:0];
                lane_next.ri = q_im[31:0];
                lane_next.ovf = q_re[32] | q_im[32];
            end
            OP_MUL, OP_SCALE:
            begin
                if (op_reg == OP_MUL)
                begin
                    s_re = (66'(p0_reg) - 66'(p1_reg)) >>> FRAC_BITS;
                    s_im = (66'(p2_reg) + 66'(p3_reg)) >>> FRAC_BITS;
                end
                else
                begin
                    s_re = 66'(p0_reg) >>> FRAC_BITS;
                    s_im = 66'(p2_reg) >>> FRAC_BITS;
                end
                q_re = sat32(s_re);
                q_im = sat32(s_im);
                lane_next.rr = q_re[31:0];
                lane_next.ri = q_im[31:0];
                lane_next.ovf = q_re[32] | q_im[32];
            end
            OP_DIV:
            begin
                s_re = 66'(p0_reg) + 66'(p1_reg);
                s_im = 66'(p2_reg) - 66'(p3_reg);
                lane_next.den = den4;
                lane_next.err = (den4 == 64'd0) ? ERR_DIV0 : ERR_OK;
                lane_next.neg_re = s_re[65];
                lane_next.neg_im = s_im[65];
                lane_next.dvd_re = s_re[65] ? 64'(-s_re) : s_re[63:0];
                lane_next.dvd_im = s_im[65] ? 64'(-s_im) : s_im[63:0];
            end
            OP_DIVR:
            begin
                lane_next.den = 64'(mag_br);
                lane_next.err = (br_reg == 32'd0) ? ERR_DIV0 : ERR_OK;
                lane_next.neg_re = ar_reg[31] ^ br_reg[31];
                lane_next.neg_im = ai_reg[31] ^ br_reg[31];
                lane_next.dvd_re = 64'(mag_ar);
                lane_next.dvd_im = 64'(mag_ai);
            end
            OP_MOD:
            begin
                lane_next.sq_n = den4;
            end
            OP_ARG:
            begin
                lane_next.err = (ar_reg == 32'd0) ? ERR_ARG0 : ERR_OK;
                lane_next.cx = 34'(mag_ar);
                lane_next.cy = ar_reg[31] ? -34'($signed(ai_reg)) : 34'($signed(ai_reg));
            end
            OP_EQ:
            begin
                lane_next.eq = (ar_reg == br_reg) && (ai_reg == bi_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_vld = vld1_reg;
    assign out_lane = lane_reg;

endmodule

[rtl/core/cau_cell.sv]
// Chain cell: a quotient bit per part; square-root and CORDIC steps in the leading cells.
module cau_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  cau_pkg::cau_lane_t in_lane,
    output logic               out_vld,
    output cau_pkg::cau_lane_t out_lane
);
    import cau_pkg::*;

    logic      vld_reg;
    cau_lane_t lane_reg;
    cau_lane_t lane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    always_comb
    begin
        logic [64:0]        t_re, t_im;
        logic               ge_re, ge_im;
        logic [63:0]        sbit, strial;
        logic signed [33:0] x, y, dx, dy;
        logic signed [32:0] z, a;
        lane_next = in_lane;

        t_re = {in_lane.rem_re, in_lane.dvd_re[63]};
        t_im = {in_lane.rem_im, in_lane.dvd_im[63]};
        ge_re = t_re >= {1'b0, in_lane.den};
        ge_im = t_im >= {1'b0, in_lane.den};
        lane_next.rem_re = ge_re ? 64'(t_re - {1'b0, in_lane.den}) : t_re[63:0];
        lane_next.rem_im = ge_im ? 64'(t_im - {1'b0, in_lane.den}) : t_im[63:0];
        lane_next.dvd_re = in_lane.dvd_re << 1;
        lane_next.dvd_im = in_lane.dvd_im << 1;
        lane_next.quo_re = {in_lane.quo_re[31:0], ge_re};
        lane_next.quo_im = {in_lane.quo_im[31:0], ge_im};
        lane_next.big_re = in_lane.big_re | in_lane.quo_re[32];
        lane_next.big_im = in_lane.big_im | in_lane.quo_im[32];

        sbit = '0;
        strial = '0;
        if (IDX < SQRT_STEPS)
        begin
            sbit = 64'd1 << (62 - 2 * (IDX % SQRT_STEPS));
            strial = in_lane.sq_res + sbit;
            if (in_lane.sq_n >= strial)
            begin
                lane_next.sq_n = in_lane.sq_n - strial;
                lane_next.sq_res = (in_lane.sq_res >> 1) + sbit;
            end
            else
            begin
                lane_next.sq_res = in_lane.sq_res >> 1;
            end
        end

        x = $signed(in_lane.cx);
        y = $signed(in_lane.cy);
        z = $signed(in_lane.cz);
        dx = y >>> (IDX % CORDIC_STEPS);
        dy = x >>> (IDX % CORDIC_STEPS);
        a = $signed({1'b0, ATAN_Q30[IDX % CORDIC_STEPS]});
        if (IDX < CORDIC_STEPS)
        begin
            if (y > 34'sd0)
            begin
                lane_next.cx = x + dx;
                lane_next.cy = y - dy;
                lane_next.cz = z + a;
            end
            else if (y < 34'sd0)
            begin
                lane_next.cx = x - dx;
                lane_next.cy = y + dy;
                lane_next.cz = z - a;
            end
        end
    end

    assign out_vld = vld_reg;
    assign out_lane = lane_reg;

endmodule

[sim/tb_complex_arithmetic_unit.sv]
// Self-checking testbench for the complex arithmetic unit with directed and random requests.
module tb_complex_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    localparam int FB = DEF_FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 2 * (FB + 67);
    localparam logic signed [65:0] I32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] I32_MIN = -66'sd2147483648;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        ovf;
        logic [1:0]  err;
    } cau_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  req_type;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
    logic        done;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        equal_flag;
    logic        overflow;
    logic [1:0]  error_code;

    cau_result_t expected_results[$];
    int unsigned accepted_words;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    bit          timed_out;

    complex_arithmetic_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req_type(req_type),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
        .res_re(res_re), .res_im(res_im), .equal_flag(equal_flag),
        .overflow(overflow), .error_code(error_code)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] saturate(input logic signed [65:0] v, inout logic ovf);
        logic [31:0] r;
        if (v > I32_MAX) begin
            ovf = 1'b1;
            r = 32'h7FFF_FFFF;
        end
        else if (v < I32_MIN) begin
            ovf = 1'b1;
            r = 32'h8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] fixed_quotient(input logic [65:0] mag, input logic [65:0] den,
                                                   input logic neg, inout logic ovf);
        logic [95:0] q;
        logic [31:0] r;
        q = {mag[63:0], 32'd0} >> (32 - FB);
        q = q / {32'd0, den[63:0]};
        if (neg) begin
            if (q > 96'h8000_0000) begin
                ovf = 1'b1;
                r = 32'h8000_0000;
            end
            else begin
                r = 32'(96'd0 - q);
            end
        end
        else if (q > 96'h7FFF_FFFF) begin
            ovf = 1'b1;
            r = 32'h7FFF_FFFF;
        end
        else begin
            r = q[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [65:0] cordic_angle(input logic signed [65:0] re,
                                                        input logic signed [65:0] im);
        logic signed [65:0] x;
        logic signed [65:0] y;
        logic signed [65:0] z;
        logic signed [65:0] dx;
        logic signed [65:0] dy;
        x = (re < 0) ? -re : re;
        y = (re < 0) ? -im : im;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + $signed({34'd0, ATAN_Q30[i]});
            end
            else if (y < 0) begin
                x = x - dx;
                y = y + dy;
                z = z - $signed({34'd0, ATAN_Q30[i]});
            end
        end
        if (FB < 30) z = (z + (66'sd1 <<< (29 - FB))) >>> (30 - FB);
        return z;
    endfunction

    function automatic cau_result_t compute_result(input logic [3:0] op,
                                                   input logic [31:0] ar_u, input logic [31:0] ai_u,
                                                   input logic [31:0] br_u, input logic [31:0] bi_u);
        cau_result_t r;
        logic signed [65:0] ar;
        logic signed [65:0] ai;
        logic signed [65:0] br;
        logic signed [65:0] bi;
        logic signed [65:0] num_re;
        logic signed [65:0] num_im;
        logic signed [65:0] den;
        logic [63:0] m;
        logic ovf;
        ar = $signed(ar_u);
        ai = $signed(ai_u);
        br = $signed(br_u);
        bi = $signed(bi_u);
        r = '0;
        ovf = 1'b0;
        case (op)
            OP_ADD: begin
                r.re = saturate(ar + br, ovf);
                r.im = saturate(ai + bi, ovf);
            end
            OP_SUB: begin
                r.re = saturate(ar - br, ovf);
                r.im = saturate(ai - bi, ovf);
            end
            OP_MUL: begin
                r.re = saturate((ar * br - ai * bi) >>> FB, ovf);
                r.im = saturate((ai * br + ar * bi) >>> FB, ovf);
            end
            OP_SCALE: begin
                r.re = saturate((ar * br) >>> FB, ovf);
                r.im = saturate((ai * br) >>> FB, ovf);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.err = ERR_DIV0;
                end
                else begin
                    num_re = ar * br + ai * bi;
                    num_im = ai * br - ar * bi;
                    r.re = fixed_quotient((num_re < 0) ? -num_re : num_re, den, num_re < 0, ovf);
                    r.im = fixed_quotient((num_im < 0) ? -num_im : num_im, den, num_im < 0, ovf);
                end
            end
            OP_DIVR: begin
                if (br == 0) begin
                    r.err = ERR_DIV0;
                end
                else begin
                    den = (br < 0) ? -br : br;
                    r.re = fixed_quotient((ar < 0) ? -ar : ar, den, (ar < 0) != (br < 0), ovf);
                    r.im = fixed_quotient((ai < 0) ? -ai : ai, den, (ai < 0) != (br < 0), ovf);
                end
            end
            OP_NEG: begin
                r.re = saturate(-ar, ovf);
                r.im = saturate(-ai, ovf);
            end
            OP_MOD: begin
                den = ar * ar + ai * ai;
                m = floor_sqrt(den[63:0]);
                if (m > 64'h7FFF_FFFF) begin
                    ovf = 1'b1;
                    m = 64'h7FFF_FFFF;
                end
                r.re = m[31:0];
            end
            OP_ARG: begin
                if (ar == 0) r.err = ERR_ARG0;
                else r.re = saturate(cordic_angle(ar, ai), ovf);
            end
            OP_EQ: r.eq = (ar_u == br_u) && (ai_u == bi_u);
            default: r = '0;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    always @(posedge clk) begin
        cau_result_t exp_r;
        if (rst_n) begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("Unexpected result word re=%h", res_re);
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.re !== res_re || exp_r.im !== res_im || exp_r.eq !== equal_flag
                        || exp_r.ovf !== overflow || exp_r.err !== error_code) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"Mismatch: expected re=%h im=%h eq=%b ovf=%b err=%0d,",
                                      " got re=%h im=%h eq=%b ovf=%b err=%0d"},
                                     exp_r.re, exp_r.im, exp_r.eq, exp_r.ovf, exp_r.err,
                                     res_re, res_im, equal_flag, overflow, error_code);
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(compute_result(req_type, a_re, a_im, b_re, b_im));
                accepted_words++;
            end
            if (done || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
    end

    always @(posedge clk) begin
        if (timed_out) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [3:0] op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        int unsigned gap;
        int unsigned count_before;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        count_before = accepted_words;
        start <= 1'b1;
        req_type <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        do @(negedge clk); while (accepted_words == count_before);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'd0;
            3: v = 32'(1 << FB);
            4: v = 32'(-(1 << FB));
            5: v = 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            6: v = 32'($signed($urandom_range(0, 32'hFF)) - 32'sh80);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    task automatic test_field_extremes();
        logic [31:0] vals[4];
        vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};
        for (int op = OP_ADD; op <= OP_EQ; op++)
            send_word(4'(op), vals[op % 4], vals[(op + 1) % 4], vals[(op + 2) % 4],
                      vals[(op + 3) % 4]);
        send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_MOD, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_word(OP_MOD, 32'hFFFD_0000, 32'd0, 32'd0, 32'd0);
        send_word(OP_NEG, 32'h8000_0000, 32'h0001_0000, 32'd0, 32'd0);
    endtask

    task automatic test_special_cases();
        send_word(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0);
        send_word(OP_DIVR, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'h1234_5678);
        send_word(OP_ARG, 32'd0, 32'h0001_0000, 32'd5, 32'd7);
        send_word(OP_ARG, 32'hFFFF_0000, 32'h8000_0000, 32'd0, 32'd0);
        send_word(OP_EQ, 32'h1234_5678, 32'h9ABC_DEF0, 32'h1234_5678, 32'h9ABC_DEF0);
        send_word(OP_DIVR, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0);
        send_word(4'd10, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444);
        send_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_mix(input int unsigned n);
        logic [3:0]  op;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        for (int unsigned i = 0; i < n; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            ar = pick_value();
            ai = pick_value();
            br = pick_value();
            bi = pick_value();
            if ($urandom_range(0, 9) == 0) begin
                br = 32'd0;
                if ($urandom_range(0, 1) == 0) bi = 32'd0;
            end
            if ($urandom_range(0, 9) == 0) ar = 32'd0;
            if (op == OP_EQ && $urandom_range(0, 1) == 0) begin
                br = ar;
                bi = ai;
            end
            send_word(op, ar, ai, br, bi);
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = '0;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        accepted_words = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_field_extremes();
        test_special_cases();
        test_random_mix(900);
        wait_for_drain();
        test_random_mix(1050);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
